/* src/thi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_pkg
// Shared constants, codes and types of the terrain height interpolator.
// ----------------------------------------------------------------------------
package thi_pkg;

  // Grid geometry; the store is split in four banks by column/row parity,
  // so GRID_DIM is expected to be at least 4.
  localparam int GRID_DIM   = 1024;
  localparam int IDX_W      = $clog2(GRID_DIM);
  localparam int BANK_AW    = 2 * (IDX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Field widths
  localparam int COORD_W     = 32;
  localparam int WIDX_W      = 10;
  localparam int GRID_PTS_W  = 11;
  localparam int SPACING_W   = 31;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_IDX_W   = 1;
  localparam int STATUS_W    = 2;
  localparam int FRAC_W      = 16;
  localparam int RATIO_W     = FRAC_W + 1;

  localparam logic [RATIO_W-1:0] ONE_Q16 = RATIO_W'(1) << FRAC_W;

  // Register reset values
  localparam logic [GRID_PTS_W-1:0] GRID_PTS_RST = GRID_PTS_W'(1024);
  localparam logic [SPACING_W-1:0]  SPACING_RST  = SPACING_W'(262144);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPACING = 1'b1;

  // Request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOB = 2'd2;

  // Cell corners as {dx, dz} offsets from (ix, iz)
  localparam logic [1:0] CORNER_00 = 2'b00;
  localparam logic [1:0] CORNER_01 = 2'b01;
  localparam logic [1:0] CORNER_10 = 2'b10;
  localparam logic [1:0] CORNER_11 = 2'b11;

  typedef struct packed {
    logic                      mode;
    logic [WIDX_W-1:0]         write_col;
    logic [WIDX_W-1:0]         write_row;
    logic signed [COORD_W-1:0] sample_height;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] object_height;
    logic                      object_present;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] height;
    logic [STATUS_W-1:0]       status;
    logic                      from_object;
  } out_t;

  // Request state carried down the pipeline
  typedef struct packed {
    logic                query;
    logic [WIDX_W-1:0]   wr_col;
    logic [WIDX_W-1:0]   wr_row;
    logic [COORD_W-1:0]  wr_height;
    logic [STATUS_W-1:0] status;
    logic                oob;
    logic [IDX_W-1:0]    ix;
    logic [IDX_W-1:0]    iz;
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fz;
    logic [RATIO_W-1:0]  ratio;
    logic [1:0]          p1;
    logic [1:0]          q1;
    logic [1:0]          p2;
    logic [1:0]          q2;
    logic                swap;
    logic                shortcut;
    logic [COORD_W-1:0]  obj;
    logic                obj_present;
  } item_t;

  // One height per bank, indexed {col parity, row parity}
  typedef logic [3:0][COORD_W-1:0] heights4_t;

endpackage

/* src/terrain_height_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_height_interpolator
// Triangulated heightmap lookup over a banked Q16.16 height grid.
// ----------------------------------------------------------------------------
// One request enters per clock unless stalled. A query passes 27 stages of
// cell index and fraction division, 18 stages for bounds check and the
// triangle ratio divider, one banked memory read, five blend stages and the
// output register. Write requests produce no result and update the grid when
// they pass the memory stage, so any later query sees them. If a result is
// held by out_stall_i, one more result is parked in a skid register and then
// in_stall_o rises until the held result is taken. The user must write
// registers through the configuration port only while no request is in flight;
// the block does not check. The grid has no reset; read cells must be written.
// ----------------------------------------------------------------------------
module terrain_height_interpolator
  import thi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Requests
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_req_i,
  // Results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_res_o,
  // Configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [GRID_PTS_W-1:0] grid_points_q;
  logic [SPACING_W-1:0]  cell_spacing_q;
  logic [SPACING_W-1:0]  spacing_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_points_q  <= GRID_PTS_RST;
      cell_spacing_q <= SPACING_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRID_POINTS:  grid_points_q  <= cfg_data_i[GRID_PTS_W-1:0];
        CFG_CELL_SPACING: cell_spacing_q <= cfg_data_i[SPACING_W-1:0];
        default:          ;
      endcase
    end
  end

  // Zero spacing behaves as one
  assign spacing_eff = (cell_spacing_q == '0) ? SPACING_W'(1) : cell_spacing_q;

  // Pipeline advance; the skid register holds the overflow result
  logic adv;
  logic skid_valid_q, out_valid_q;
  out_t skid_q, out_q;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Entry request
  item_t it_in;

  always_comb begin
    it_in             = '0;
    it_in.query       = (in_req_i.mode == MODE_QUERY);
    it_in.wr_col      = in_req_i.write_col;
    it_in.wr_row      = in_req_i.write_row;
    it_in.wr_height   = in_req_i.sample_height;
    it_in.status      = (in_req_i.pos_x[COORD_W-1] || in_req_i.pos_z[COORD_W-1]) ?
                        STATUS_NEG : STATUS_OK;
    it_in.obj         = in_req_i.object_height;
    it_in.obj_present = in_req_i.object_present;
  end

  logic      cd_valid, rd_valid, ram_valid, bl_valid;
  item_t     cd_item, rd_item, ram_item;
  heights4_t ram_rd;
  out_t      bl_res;

  thi_cell_div u_cell_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (in_valid_i),
    .item_i    (it_in),
    .pos_x_i   (in_req_i.pos_x[SPACING_W-1:0]),
    .pos_z_i   (in_req_i.pos_z[SPACING_W-1:0]),
    .spacing_i (spacing_eff),
    .valid_o   (cd_valid),
    .item_o    (cd_item)
  );

  thi_ratio_div u_ratio_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (cd_valid),
    .item_i        (cd_item),
    .grid_points_i (grid_points_q),
    .valid_o       (rd_valid),
    .item_o        (rd_item)
  );

  thi_height_ram u_height_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (rd_valid),
    .item_i  (rd_item),
    .valid_o (ram_valid),
    .item_o  (ram_item),
    .rd_o    (ram_rd)
  );

  thi_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (ram_valid),
    .item_i  (ram_item),
    .rd_i    (ram_rd),
    .valid_o (bl_valid),
    .res_o   (bl_res)
  );

  // Output register with one skid entry
  logic take, last_fire;

  assign take      = out_valid_q && !out_stall_i;
  assign last_fire = bl_valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q || last_fire;
      skid_valid_q <= 1'b0;
    end else if (last_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : bl_res;
    end else if (last_fire) begin
      skid_q <= bl_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output result");

  a_skid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_stall_i |=> skid_valid_q)
    else $error("skid entry dropped while output stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.status == STATUS_OK || out_res_o.status == STATUS_NEG ||
                     out_res_o.status == STATUS_OOB))
    else $error("undefined status code");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status != STATUS_OK |->
      out_res_o.height == '0 && !out_res_o.from_object)
    else $error("failed lookup carries a height");
`endif

endmodule

/* src/thi_cell_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_cell_div
// Pipelined divider for x and z: cell index (one bit per stage, with an
// overflow check up front) then the Q0.16 fraction (one bit per stage).
// ----------------------------------------------------------------------------
module thi_cell_div
  import thi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  item_t                item_i,
  input  logic [SPACING_W-1:0] pos_x_i,
  input  logic [SPACING_W-1:0] pos_z_i,
  input  logic [SPACING_W-1:0] spacing_i,
  output logic                 valid_o,
  output item_t                item_o
);

  localparam int NST    = 1 + IDX_W + FRAC_W;
  localparam int REM_W  = SPACING_W + 1;
  localparam int WIDE_W = SPACING_W + IDX_W;

  logic [NST-1:0]          v_q;
  item_t                   it_q  [NST];
  logic [1:0][REM_W-1:0]   rem_q [NST];

  // Restoring step against the divisor shifted to an index bit
  function automatic logic [REM_W:0] idx_step(input logic [REM_W-1:0]  r,
                                              input logic [WIDE_W-1:0] d);
    logic [WIDE_W-1:0] rw;
    rw = {{(WIDE_W-REM_W){1'b0}}, r};
    if (rw >= d) return {1'b1, r - d[REM_W-1:0]};
    return {1'b0, r};
  endfunction

  // Restoring step for one fraction bit
  function automatic logic [REM_W:0] frac_step(input logic [REM_W-1:0]     r,
                                               input logic [SPACING_W-1:0] s);
    logic [REM_W-1:0] t;
    t = {r[REM_W-2:0], 1'b0};
    if (t >= {1'b0, s}) return {1'b1, t - {1'b0, s}};
    return {1'b0, t};
  endfunction

  // Entry: a quotient of GRID_DIM or more can never be inside the grid
  item_t                 it0_d;
  logic [1:0][REM_W-1:0] rem0_d;
  logic                  over_x, over_z;

  always_comb begin
    over_x = {{IDX_W{1'b0}}, pos_x_i} >= {spacing_i, {IDX_W{1'b0}}};
    over_z = {{IDX_W{1'b0}}, pos_z_i} >= {spacing_i, {IDX_W{1'b0}}};
    it0_d     = item_i;
    it0_d.oob = over_x | over_z;
    rem0_d[0] = {1'b0, pos_x_i};
    rem0_d[1] = {1'b0, pos_z_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q[0]  <= it0_d;
      rem_q[0] <= rem0_d;
    end
  end

  for (genvar j = 1; j < NST; j++) begin : g_stage
    item_t                 it_d;
    logic [1:0][REM_W-1:0] rem_d;

    if (j <= IDX_W) begin : g_idx
      localparam int K = IDX_W - j;
      logic [WIDE_W-1:0] dsh;
      assign dsh = {{IDX_W{1'b0}}, spacing_i} << K;
      always_comb begin
        it_d  = it_q[j-1];
        rem_d = rem_q[j-1];
        {it_d.ix[K], rem_d[0]} = idx_step(rem_q[j-1][0], dsh);
        {it_d.iz[K], rem_d[1]} = idx_step(rem_q[j-1][1], dsh);
      end
    end else begin : g_frac
      localparam int FB = FRAC_W + IDX_W - j;
      always_comb begin
        it_d  = it_q[j-1];
        rem_d = rem_q[j-1];
        {it_d.fx[FB], rem_d[0]} = frac_step(rem_q[j-1][0], spacing_i);
        {it_d.fz[FB], rem_d[1]} = frac_step(rem_q[j-1][1], spacing_i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (adv_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        it_q[j]  <= it_d;
        rem_q[j] <= rem_d;
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign item_o  = it_q[NST-1];

endmodule

/* src/thi_ratio_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_ratio_div
// Grid bounds check, triangle selection and the pipelined Q1.16 triangle
// ratio divider (one quotient bit per stage).
// ----------------------------------------------------------------------------
module thi_ratio_div
  import thi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  item_t                 item_i,
  input  logic [GRID_PTS_W-1:0] grid_points_i,
  output logic                  valid_o,
  output item_t                 item_o
);

  localparam int NST   = RATIO_W + 1;
  localparam int REM_W = RATIO_W + 1;
  localparam int NE_W  = IDX_W + 1;

  logic [NST-1:0]     v_q;
  item_t              it_q  [NST];
  logic [REM_W-1:0]   rem_q [NST];
  logic [RATIO_W-1:0] den_q [NST];

  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0]   t,
                                              input logic [RATIO_W-1:0] d);
    if (t >= {1'b0, d}) return {1'b1, t - {1'b0, d}};
    return {1'b0, t};
  endfunction

  // Entry: bounds, split parity, triangle side, ratio operands
  item_t              it0_d;
  logic [NE_W-1:0]    n_eff, ixp, izp;
  logic [RATIO_W-1:0] fx1, fz1, num, den;
  logic [RATIO_W:0]   fsum;
  logic               odd;

  always_comb begin
    it0_d = item_i;
    n_eff = (32'(grid_points_i) > GRID_DIM) ? NE_W'(GRID_DIM) : NE_W'(grid_points_i);
    ixp   = {1'b0, item_i.ix} + NE_W'(1);
    izp   = {1'b0, item_i.iz} + NE_W'(1);
    if (item_i.status == STATUS_OK && (item_i.oob || ixp >= n_eff || izp >= n_eff)) begin
      it0_d.status = STATUS_OOB;
    end

    fx1  = {1'b0, item_i.fx};
    fz1  = {1'b0, item_i.fz};
    fsum = {1'b0, fx1} + {1'b0, fz1};
    odd  = item_i.ix[0] ^ item_i.iz[0];
    it0_d.shortcut = 1'b0;
    it0_d.ratio    = '0;

    if (odd) begin
      it0_d.swap = 1'b1;
      if (fsum < {1'b0, ONE_Q16}) begin
        it0_d.p1 = CORNER_01; it0_d.q1 = CORNER_10;
        it0_d.p2 = CORNER_00; it0_d.q2 = CORNER_10;
        num = fz1;
        den = ONE_Q16 - fx1;
      end else begin
        it0_d.p1 = CORNER_01; it0_d.q1 = CORNER_10;
        it0_d.p2 = CORNER_01; it0_d.q2 = CORNER_11;
        num = ONE_Q16 - fz1;
        den = fx1;
        it0_d.shortcut = (item_i.fx == '0);
      end
    end else begin
      it0_d.swap = 1'b0;
      if (item_i.fz > item_i.fx) begin
        it0_d.p1 = CORNER_01; it0_d.q1 = CORNER_11;
        it0_d.p2 = CORNER_00; it0_d.q2 = CORNER_11;
        num = ONE_Q16 - fz1;
        den = ONE_Q16 - fx1;
      end else begin
        it0_d.p1 = CORNER_00; it0_d.q1 = CORNER_10;
        it0_d.p2 = CORNER_00; it0_d.q2 = CORNER_11;
        num = fz1;
        den = fx1;
        it0_d.shortcut = (item_i.fx == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q[0]  <= it0_d;
      rem_q[0] <= {1'b0, num};
      den_q[0] <= den;
    end
  end

  // Quotient bits from the integer bit down; num <= den keeps it <= 1.0
  // A zero divisor only occurs on the shortcut path, where the ratio is unused.
  for (genvar j = 1; j < NST; j++) begin : g_stage
    localparam int B = RATIO_W - j;
    item_t            it_d;
    logic [REM_W-1:0] rem_d;
    logic [REM_W-1:0] t;

    if (j == 1) begin : g_first
      assign t = rem_q[j-1];
    end else begin : g_next
      assign t = {rem_q[j-1][REM_W-2:0], 1'b0};
    end

    always_comb begin
      it_d = it_q[j-1];
      {it_d.ratio[B], rem_d} = div_step(t, den_q[j-1]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (adv_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        it_q[j]  <= it_d;
        rem_q[j] <= rem_d;
        den_q[j] <= den_q[j-1];
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign item_o  = it_q[NST-1];

endmodule

/* src/thi_height_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_height_ram
// Height store in four banks by column/row parity, so the four corners of
// any cell sit in different banks and are read together. Write requests
// update the store here, in request order; only queries continue.
// ----------------------------------------------------------------------------
module thi_height_ram
  import thi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      valid_i,
  input  item_t     item_i,
  output logic      valid_o,
  output item_t     item_o,
  output heights4_t rd_o
);

  logic       v_q;
  item_t      it_q;
  heights4_t  rd_q;

  logic             wr_ok;
  logic [IDX_W-1:0] wcol, wrow;

  assign wr_ok = (32'(item_i.wr_col) < GRID_DIM) && (32'(item_i.wr_row) < GRID_DIM);
  assign wcol  = IDX_W'(item_i.wr_col);
  assign wrow  = IDX_W'(item_i.wr_row);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PC = 1'(b >> 1);
    localparam logic PR = 1'(b);

    logic [COORD_W-1:0] bank_mem [BANK_DEPTH];
    logic [IDX_W-1:0]   rcol, rrow;
    logic [BANK_AW-1:0] raddr, waddr;
    logic               we, re;

    // Corner of this bank's parity for the queried cell
    assign rcol  = item_i.ix + IDX_W'(PC ^ item_i.ix[0]);
    assign rrow  = item_i.iz + IDX_W'(PR ^ item_i.iz[0]);
    assign raddr = {rcol[IDX_W-1:1], rrow[IDX_W-1:1]};
    assign waddr = {wcol[IDX_W-1:1], wrow[IDX_W-1:1]};
    assign we = adv_i && valid_i && !item_i.query && wr_ok &&
                (wcol[0] == PC) && (wrow[0] == PR);
    assign re = adv_i && valid_i && item_i.query;

    always_ff @(posedge clk_i) begin
      if (we) begin
        bank_mem[waddr] <= item_i.wr_height;
      end
      if (re) begin
        rd_q[b] <= bank_mem[raddr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv_i) begin
      v_q <= valid_i && item_i.query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q <= item_i;
    end
  end

  assign valid_o = v_q;
  assign item_o  = it_q;
  assign rd_o    = rd_q;

endmodule

/* src/thi_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_blend
// Corner selection, both edge blends by fx, the final blend by the triangle
// ratio, then object height and status. No stage chains multiplies.
// ----------------------------------------------------------------------------
module thi_blend
  import thi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      valid_i,
  input  item_t     item_i,
  input  heights4_t rd_i,
  output logic      valid_o,
  output out_t      res_o
);

  localparam int PROD_W = COORD_W + RATIO_W + 2;

  function automatic logic [COORD_W-1:0] pick(input heights4_t rd, input logic [1:0] c,
                                              input logic ix0, input logic iz0);
    return rd[{c[1] ^ ix0, c[0] ^ iz0}];
  endfunction

  logic [4:0] v_q;
  item_t      it0_q, it1_q, it2_q, it3_q;

  // Stage 0: corner heights
  logic [COORD_W-1:0] p1_q, q1_q, p2_q, q2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it0_q <= item_i;
      p1_q  <= pick(rd_i, item_i.p1, item_i.ix[0], item_i.iz[0]);
      q1_q  <= pick(rd_i, item_i.q1, item_i.ix[0], item_i.iz[0]);
      p2_q  <= pick(rd_i, item_i.p2, item_i.ix[0], item_i.iz[0]);
      q2_q  <= pick(rd_i, item_i.q2, item_i.ix[0], item_i.iz[0]);
    end
  end

  // Stage 1: edge products (b - a) * fx
  logic signed [COORD_W:0]  d1, d2;
  logic signed [PROD_W-1:0] m1_d, m2_d;
  logic signed [PROD_W-1:0] m1_q, m2_q;
  logic [COORD_W-1:0]       p1b_q, p2b_q;

  always_comb begin
    d1   = $signed({q1_q[COORD_W-1], q1_q}) - $signed({p1_q[COORD_W-1], p1_q});
    d2   = $signed({q2_q[COORD_W-1], q2_q}) - $signed({p2_q[COORD_W-1], p2_q});
    m1_d = d1 * $signed({2'b00, it0_q.fx});
    m2_d = d2 * $signed({2'b00, it0_q.fx});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it1_q <= it0_q;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      p1b_q <= p1_q;
      p2b_q <= p2_q;
    end
  end

  // Stage 2: edge heights; floor shift, stays between the two ends
  logic [COORD_W-1:0] e1, e2;
  logic [COORD_W-1:0] a_q, b_q, hs2_q;

  assign e1 = p1b_q + m1_q[FRAC_W+COORD_W-1:FRAC_W];
  assign e2 = p2b_q + m2_q[FRAC_W+COORD_W-1:FRAC_W];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it2_q <= it1_q;
      a_q   <= it1_q.swap ? e2 : e1;
      b_q   <= it1_q.swap ? e1 : e2;
      hs2_q <= p1b_q;
    end
  end

  // Stage 3: final product (b - a) * ratio
  logic signed [COORD_W:0]  d3;
  logic signed [PROD_W-1:0] m3_d, m3_q;
  logic [COORD_W-1:0]       a3_q, hs3_q;

  assign d3   = $signed({b_q[COORD_W-1], b_q}) - $signed({a_q[COORD_W-1], a_q});
  assign m3_d = d3 * $signed({1'b0, it2_q.ratio});

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it3_q <= it2_q;
      m3_q  <= m3_d;
      a3_q  <= a_q;
      hs3_q <= hs2_q;
    end
  end

  // Stage 4: terrain height, object override, status
  logic [COORD_W-1:0] y;
  out_t               res_d, res_q;

  assign y = a3_q + m3_q[FRAC_W+COORD_W-1:FRAC_W];

  always_comb begin
    res_d.status      = it3_q.status;
    res_d.height      = '0;
    res_d.from_object = 1'b0;
    if (it3_q.status == STATUS_OK) begin
      if (it3_q.shortcut) begin
        res_d.height = hs3_q;
      end else if (it3_q.obj_present && $signed(it3_q.obj) > $signed(y)) begin
        res_d.height      = it3_q.obj;
        res_d.from_object = 1'b1;
      end else begin
        res_d.height = y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  assign valid_o = v_q[4];
  assign res_o   = res_q;

endmodule

/* sim/thi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_checker
// Watches the request, result and configuration channels of the terrain
// height interpolator, keeps a shadow of the height grid and the registers,
// predicts each query result in order and compares it field by field.
// ----------------------------------------------------------------------------
module thi_checker
  import thi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_t                   in_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_t                  out_res_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    writes_o
);

  // Shadow state
  int                    grid_heights[int];
  logic [GRID_PTS_W-1:0] grid_pts_q;
  logic [SPACING_W-1:0]  spacing_q;
  out_t                  expected_heights[$];

  function automatic longint corner_h(longint c, longint r);
    int key;
    key = int'(c) * GRID_DIM + int'(r);
    return grid_heights.exists(key) ? longint'(grid_heights[key]) : 0;
  endfunction

  // a + floor((b - a) * t / 2^16)
  function automatic longint mix_q16(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> FRAC_W);
  endfunction

  function automatic longint frac_ratio(longint num, longint den);
    return (den == 0) ? 0 : (num << FRAC_W) / den;
  endfunction

  function automatic out_t predict_height(in_t r);
    longint px, pz, obj, s, n, ix, iz, fx, fz, ha, hb, hc, ea, eb, y, one;
    bit     hit_corner;
    out_t   o;
    one = longint'(ONE_Q16);
    px = r.pos_x;
    pz = r.pos_z;
    obj = r.object_height;
    o = '0;
    y = 0;
    hit_corner = 0;
    if (px < 0 || pz < 0) begin
      o.status = STATUS_NEG;
      return o;
    end
    s = (spacing_q == 0) ? 1 : longint'(spacing_q);
    n = (grid_pts_q < GRID_DIM) ? longint'(grid_pts_q) : GRID_DIM;
    ix = px / s;
    iz = pz / s;
    if (ix + 1 >= n || iz + 1 >= n) begin
      o.status = STATUS_OOB;
      return o;
    end
    fx = ((px % s) << FRAC_W) / s;
    fz = ((pz % s) << FRAC_W) / s;
    if (((ix + iz) & 1) == 1) begin
      // odd cell: split along the anti-diagonal
      ha = corner_h(ix, iz + 1);
      hb = corner_h(ix + 1, iz);
      if (fx + fz < one) begin
        hc = corner_h(ix, iz);
        ea = mix_q16(ha, hb, fx);
        eb = mix_q16(hc, hb, fx);
        y = mix_q16(eb, ea, frac_ratio(fz, one - fx));
      end else begin
        hc = corner_h(ix + 1, iz + 1);
        if (fx == 0) begin
          y = ha;
          hit_corner = 1;
        end else begin
          ea = mix_q16(ha, hb, fx);
          eb = mix_q16(ha, hc, fx);
          y = mix_q16(eb, ea, frac_ratio(one - fz, fx));
        end
      end
    end else begin
      // even cell: split along the main diagonal
      if (fz > fx) begin
        ha = corner_h(ix, iz + 1);
        hb = corner_h(ix + 1, iz + 1);
        hc = corner_h(ix, iz);
        ea = mix_q16(ha, hb, fx);
        eb = mix_q16(hc, hb, fx);
        y = mix_q16(ea, eb, frac_ratio(one - fz, one - fx));
      end else begin
        ha = corner_h(ix, iz);
        hb = corner_h(ix + 1, iz);
        hc = corner_h(ix + 1, iz + 1);
        if (fx == 0) begin
          y = ha;
          hit_corner = 1;
        end else begin
          ea = mix_q16(ha, hb, fx);
          eb = mix_q16(ha, hc, fx);
          y = mix_q16(ea, eb, frac_ratio(fz, fx));
        end
      end
    end
    if (y > 64'sh7FFFFFFF) y = 64'sh7FFFFFFF;
    if (y < -64'sh80000000) y = -64'sh80000000;
    if (!hit_corner && r.object_present && obj > y) begin
      y = obj;
      o.from_object = 1'b1;
    end
    o.height = y[COORD_W-1:0];
    o.status = STATUS_OK;
    return o;
  endfunction

  assign pending_o = expected_heights.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      grid_pts_q <= GRID_PTS_RST;
      spacing_q <= SPACING_RST;
      expected_heights.delete();
      fail_count_o <= 0;
      checked_o <= 0;
      writes_o <= 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_GRID_POINTS) grid_pts_q <= cfg_data_i[GRID_PTS_W-1:0];
        else if (cfg_index_i == CFG_CELL_SPACING) spacing_q <= cfg_data_i[SPACING_W-1:0];
      end
      // accepted requests: writes update the shadow grid, queries are predicted
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.mode == MODE_WRITE) begin
          grid_heights[int'(in_req_i.write_col) * GRID_DIM + int'(in_req_i.write_row)] =
            in_req_i.sample_height;
          writes_o <= writes_o + 1;
        end else begin
          expected_heights.push_back(predict_height(in_req_i));
        end
      end
      // accepted results
      if (out_valid_i && !out_stall_i) begin
        if (expected_heights.size() == 0) begin
          $error("unexpected result: height %0d status %0d", out_res_i.height,
                 out_res_i.status);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_heights.pop_front();
          checked_o <= checked_o + 1;
          if (exp_r != out_res_i) fail_count_o <= fail_count_o + 1;
          if (exp_r.height != out_res_i.height)
            $error("height: expected %0d actual %0d", exp_r.height, out_res_i.height);
          if (exp_r.status != out_res_i.status)
            $error("status: expected %0d actual %0d", exp_r.status, out_res_i.status);
          if (exp_r.from_object != out_res_i.from_object)
            $error("from_object: expected %0d actual %0d", exp_r.from_object,
                   out_res_i.from_object);
        end
      end
    end
  end

endmodule

/* sim/tb_terrain_height_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terrain_height_interpolator
// Drives grid writes and height queries through several grid sizes and
// spacings with random gaps and output stalls; a side checker predicts and
// compares every result, and this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_terrain_height_interpolator;
  import thi_pkg::*;

  localparam int     DRAIN_CYCLES = 70;
  localparam longint CYCLE_LIMIT  = 1500000;
  localparam int     PHASE_ITEMS  = 200;
  localparam int     IN_W         = $bits(in_t);

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_req;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, pending, checked, writes;

  // Stimulus-side view of the grid and config
  bit     written[int];
  longint grid_eff;
  longint spacing_eff;
  bit     quiet;
  int     stall_left;
  longint cycles = 0;
  int     sent = 0;

  terrain_height_interpolator uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_res_o(out_res),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  thi_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_res_i(out_res),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .writes_o(writes)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("terrain_height_interpolator verification failed");
      $finish;
    end
  end

  // Result-side back-pressure: mostly short bursts, a few long ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One request; returns at the edge where it was taken, or after a random gap
  task automatic send_req(in_t r);
    int gap;
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (in_stall);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_height(int col, int row, logic [31:0] h);
    in_t r;
    r = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.mode = MODE_WRITE;
    r.write_col = WIDX_W'(col);
    r.write_row = WIDX_W'(row);
    r.sample_height = h;
    written[col * GRID_DIM + row] = 1;
    send_req(r);
  endtask

  task automatic fill_corner(longint col, longint row);
    if (!written.exists(int'(col) * GRID_DIM + int'(row)))
      write_height(int'(col), int'(row), $urandom);
  endtask

  // Query; any cell it will read is written first
  task automatic query_at(logic [31:0] px, logic [31:0] pz, logic [31:0] obj, bit pres);
    in_t    r;
    longint ix, iz;
    if (!px[31] && !pz[31] && grid_eff >= 2) begin
      ix = longint'(px) / spacing_eff;
      iz = longint'(pz) / spacing_eff;
      if (ix + 1 < grid_eff && iz + 1 < grid_eff) begin
        fill_corner(ix, iz);
        fill_corner(ix + 1, iz);
        fill_corner(ix, iz + 1);
        fill_corner(ix + 1, iz + 1);
      end
    end
    r = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.mode = MODE_QUERY;
    r.pos_x = px;
    r.pos_z = pz;
    r.object_height = obj;
    r.object_present = pres;
    send_req(r);
  endtask

  // Position inside a valid cell, biased toward the low corner of the grid
  function automatic logic [31:0] grid_pos(longint idx_max);
    longint idx, rem;
    if ($urandom_range(0, 3) != 0 && idx_max > 7) idx_max = 7;
    idx = longint'($urandom_range(0, int'(idx_max)));
    case ($urandom_range(0, 5))
      0:       rem = 0;
      1:       rem = spacing_eff - 1;
      default: rem = longint'({$urandom, $urandom} & 64'h7FFFFFFFFFFFFFFF) % spacing_eff;
    endcase
    return 32'(idx * spacing_eff + rem);
  endfunction

  task automatic random_query();
    longint      idx_max;
    logic [31:0] px, pz;
    int          pick;
    pick = $urandom_range(0, 99);
    idx_max = 64'h80000000 / spacing_eff - 1;
    if (idx_max > grid_eff - 2) idx_max = grid_eff - 2;
    if (pick < 12) begin
      px = $urandom;
      pz = $urandom;
      if (!px[31] && !pz[31]) px[31] = 1'b1;
    end else if (pick < 25 || idx_max < 0) begin
      px = $urandom & 32'h7FFFFFFF;
      pz = $urandom & 32'h7FFFFFFF;
    end else begin
      px = grid_pos(idx_max);
      pz = grid_pos(idx_max);
    end
    query_at(px, pz, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Wait until nothing is in flight
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRID_POINTS)
      grid_eff = (data[GRID_PTS_W-1:0] < GRID_DIM) ? data[GRID_PTS_W-1:0] : GRID_DIM;
    else
      spacing_eff = (data == 0) ? 1 : longint'(data);
  endtask

  // Sends about the given number of requests, corner fills included
  task automatic run_phase(int gpts, logic [30:0] spc, int items, bit pause_mid);
    logic [CFG_DATA_W-1:0] d;
    int                    stop;
    bit                    paused;
    d = CFG_DATA_W'($urandom);
    d[GRID_PTS_W-1:0] = GRID_PTS_W'(gpts);
    cfg_write(CFG_GRID_POINTS, d);
    cfg_write(CFG_CELL_SPACING, spc);
    stop = sent + items;
    paused = 0;
    for (int i = 0; sent < stop; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (pause_mid && !paused && sent >= stop - items / 2) begin
        drain();
        paused = 1;
      end
      if ($urandom_range(0, 4) == 0)
        write_height($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      else
        random_query();
    end
    quiet = 0;
  endtask

  initial begin
    logic [31:0] sp;
    quiet = 0;
    grid_eff = GRID_PTS_RST;
    spacing_eff = SPACING_RST;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GRID_POINTS;
    cfg_data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks at the reset configuration
    sp = SPACING_RST;
    write_height(0, 0, 32'h7FFFFFFF);
    write_height(1, 0, 32'h80000000);
    write_height(0, 1, 32'h80000000);
    write_height(1, 1, 32'h7FFFFFFF);
    query_at(0, 0, 32'h7FFFFFFF, 1);                     // exact corner, object ignored
    query_at(32'hFFFFFFFF, 0, 0, 0);                     // negative x
    query_at(0, 32'h80000000, 0, 0);                     // negative z
    query_at(32'h80000000, 32'h80000000, 0, 1);          // both negative
    query_at(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1);          // far past edge
    query_at(sp / 4, sp * 3 / 4, 32'h80000000, 1);       // even, upper triangle
    query_at(sp * 3 / 4, sp / 4, 32'h7FFFFFFF, 1);       // even, lower triangle, object wins
    query_at(sp - 1, sp - 1, 0, 1);
    query_at(sp / 2, sp / 2, 32'h7FFFFFFF, 0);           // object not present
    query_at(sp + sp / 4, sp / 4, 0, 1);                 // odd, lower-left
    query_at(sp + sp * 3 / 4, sp * 3 / 4, 0, 0);         // odd, upper-right
    query_at(sp, sp / 2, 32'h80000000, 1);               // odd, zero x fraction
    query_at(sp * 1022 + 5, sp * 1022 + sp - 1, 0, 0);   // last cell
    query_at(sp * 1023, 0, 0, 0);                        // one cell past edge
    query_at(0, sp * 1023 + 1, 0, 0);

    // Random phases across grid sizes and spacings, extremes included
    run_phase(1024, SPACING_RST, PHASE_ITEMS, 0);
    run_phase(2047, 31'd65536, PHASE_ITEMS, 1);
    run_phase(2, 31'd1, PHASE_ITEMS, 0);
    run_phase(0, 31'h7FFFFFFF, 100, 0);
    run_phase(1, 31'd100, 100, 0);
    run_phase(37, 31'd0, PHASE_ITEMS, 0);
    run_phase(1024, 31'h7FFFFFFF, PHASE_ITEMS, 0);
    run_phase(5, 31'd3, PHASE_ITEMS, 0);
    run_phase(300, 31'd123457, PHASE_ITEMS, 0);
    drain();

    $display("Checked %0d query results against %0d grid writes,", checked, writes);
    $display("over nine grid size and spacing settings with random back-pressure.");
    if (fail_count == 0) begin
      $display("terrain_height_interpolator verification clean");
    end else begin
      $display("terrain_height_interpolator verification failed");
    end
    $finish;
  end

endmodule

/* terrain_height_interpolator.f */
src/thi_pkg.sv
src/thi_cell_div.sv
src/thi_ratio_div.sv
src/thi_height_ram.sv
src/thi_blend.sv
src/terrain_height_interpolator.sv
sim/thi_checker.sv
sim/tb_terrain_height_interpolator.sv
